/* sv/rtdhc_pkg.sv */
// ----------------------------------------------------------------------------
// rtdhc_pkg
// shared widths, opcodes and parameter defaults of the range table hit counter
// ----------------------------------------------------------------------------
package rtdhc_pkg;

  // fixed field widths on the stream ports
  localparam int unsigned FIELD_W  = 48;
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned COUNT_W  = 11;

  // input word: range_low, range_high, query_id from bit 0 up
  localparam int unsigned IN_DATA_W  = 3 * FIELD_W;
  // output word: hit, newly_counted, distinct_count, store_full, zero fill
  localparam int unsigned OUT_USED_W = COUNT_W + 3;
  localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // parameter defaults
  localparam int unsigned DEF_MAX_RANGES = 256;
  localparam int unsigned DEF_MAX_SEEN   = 1024;
  localparam int unsigned DEF_ID_WIDTH   = 48;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

endpackage

/* sv/rtdhc_ram.sv */
// ----------------------------------------------------------------------------
// rtdhc_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module rtdhc_ram #(
  parameter int unsigned WIDTH = rtdhc_pkg::DEF_ID_WIDTH,
  parameter int unsigned DEPTH = rtdhc_pkg::DEF_MAX_SEEN,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/rtdhc_cmp.sv */
// ----------------------------------------------------------------------------
// rtdhc_cmp
// shared compare unit: tests low <= id <= high
// ----------------------------------------------------------------------------
module rtdhc_cmp #(
  parameter int unsigned ID_WIDTH = rtdhc_pkg::DEF_ID_WIDTH
) (
  input  logic [ID_WIDTH-1:0] id,
  input  logic [ID_WIDTH-1:0] low,
  input  logic [ID_WIDTH-1:0] high,
  output logic                in_range
);

  // an equality test is the same check with low and high both set to the entry
  assign in_range = (id >= low) && (id <= high);

endmodule

/* sv/range_table_distinct_hit_counter.sv */
// ----------------------------------------------------------------------------
// range_table_distinct_hit_counter
// range table lookup with a distinct count of identifiers that hit
// ----------------------------------------------------------------------------
// One word in gives one word out. A load word appends a range to the table if
// there is room, a clear word empties table, seen store and count; both are
// accepted, then the result register is loaded. A query walks the stored ranges
// and, on a hit, the seen identifiers through one shared compare unit, one
// entry per cycle fed by the single read port of each memory, and stops early
// at the first matching range or seen entry. The block takes no word while a
// query walks; a finished result waits in the output register and the next
// word may be accepted meanwhile. Unwritten memory entries are never read, so
// no clearing pass follows reset.
// ----------------------------------------------------------------------------
module range_table_distinct_hit_counter #(
  parameter int unsigned MAX_RANGES = rtdhc_pkg::DEF_MAX_RANGES,
  parameter int unsigned MAX_SEEN   = rtdhc_pkg::DEF_MAX_SEEN,
  parameter int unsigned ID_WIDTH   = rtdhc_pkg::DEF_ID_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // range_low, range_high, query_id
  input  logic [rtdhc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // opcode
  input  logic [rtdhc_pkg::OPCODE_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // hit, newly_counted, distinct_count, store_full, zero fill
  output logic [rtdhc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned FW    = rtdhc_pkg::FIELD_W;
  localparam int unsigned CW    = rtdhc_pkg::COUNT_W;
  localparam int unsigned RA_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned RC_W  = $clog2(MAX_RANGES + 1);
  localparam int unsigned SA_W  = (MAX_SEEN > 1) ? $clog2(MAX_SEEN) : 1;
  localparam int unsigned SC_W  = $clog2(MAX_SEEN + 1);
  localparam int unsigned PAD_W = FW + ID_WIDTH;
  localparam int unsigned CPAD_W = SC_W + CW;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RANGE = 4'b0010,
    ST_SEEN  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state;

  logic [RC_W-1:0]       range_count;
  logic [SC_W-1:0]       seen_count;
  logic [RC_W-1:0]       ridx;
  logic [SC_W-1:0]       sidx;
  logic                  rd_pend;
  logic [ID_WIDTH-1:0]   qid;
  logic                  res_hit;
  logic                  res_fresh;
  logic                  res_full;

  logic [PAD_W-1:0]      low_pad, high_pad, id_pad;
  logic [ID_WIDTH-1:0]   in_low, in_high, in_id;
  logic [CPAD_W-1:0]     cnt_pad;
  logic [CW-1:0]         cnt_out;

  logic                  accept;
  logic                  range_full, seen_full;
  logic                  range_we, range_re, seen_we, seen_re;
  logic [2*ID_WIDTH-1:0] range_rdata;
  logic [ID_WIDTH-1:0]   seen_rdata;
  logic [ID_WIDTH-1:0]   cmp_low, cmp_high;
  logic                  cmp_in;
  logic                  range_hit, seen_match;
  logic                  emit_load;

  // fields are taken modulo 2^ID_WIDTH
  always_comb begin
    low_pad  = PAD_W'(s_axis_tdata[FW-1:0]);
    high_pad = PAD_W'(s_axis_tdata[2*FW-1:FW]);
    id_pad   = PAD_W'(s_axis_tdata[3*FW-1:2*FW]);
    in_low   = low_pad[ID_WIDTH-1:0];
    in_high  = high_pad[ID_WIDTH-1:0];
    in_id    = id_pad[ID_WIDTH-1:0];
    cnt_pad  = CPAD_W'(seen_count);
    cnt_out  = cnt_pad[CW-1:0];
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign range_full    = (range_count >= RC_W'(MAX_RANGES));
  assign seen_full     = (seen_count >= SC_W'(MAX_SEEN));

  // compare unit sees one seen entry in the seen walk, range bounds otherwise
  assign cmp_low  = (state == ST_SEEN) ? seen_rdata : range_rdata[ID_WIDTH-1:0];
  assign cmp_high = (state == ST_SEEN) ? seen_rdata : range_rdata[2*ID_WIDTH-1:ID_WIDTH];

  rtdhc_cmp #(
    .ID_WIDTH (ID_WIDTH)
  ) u_cmp (
    .id       (qid),
    .low      (cmp_low),
    .high     (cmp_high),
    .in_range (cmp_in)
  );

  assign range_hit  = (state == ST_RANGE) && rd_pend && cmp_in;
  assign seen_match = (state == ST_SEEN) && rd_pend && cmp_in;
  assign range_re   = (state == ST_RANGE) && !range_hit && (ridx < range_count);
  assign seen_re    = (state == ST_SEEN) && !seen_match && (sidx < seen_count);
  assign range_we   = accept && (s_axis_tuser == rtdhc_pkg::OP_LOAD) && !range_full;
  assign seen_we    = (state == ST_SEEN) && !seen_match && !seen_re && !seen_full;
  assign emit_load  = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

  rtdhc_ram #(
    .WIDTH (2 * ID_WIDTH),
    .DEPTH (MAX_RANGES)
  ) u_range_ram (
    .clk   (clk),
    .we    (range_we),
    .waddr (range_count[RA_W-1:0]),
    .wdata ({in_high, in_low}),
    .re    (range_re),
    .raddr (ridx[RA_W-1:0]),
    .rdata (range_rdata)
  );

  rtdhc_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (MAX_SEEN)
  ) u_seen_ram (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_count[SA_W-1:0]),
    .wdata (qid),
    .re    (seen_re),
    .raddr (sidx[SA_W-1:0]),
    .rdata (seen_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      range_count <= '0;
      seen_count  <= '0;
      ridx        <= '0;
      sidx        <= '0;
      rd_pend     <= 1'b0;
    end else begin
      rd_pend <= range_re || seen_re;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (s_axis_tuser)
              rtdhc_pkg::OP_LOAD: begin
                if (!range_full) begin
                  range_count <= range_count + 1'b1;
                end
                state <= ST_EMIT;
              end
              rtdhc_pkg::OP_QUERY: begin
                ridx  <= '0;
                sidx  <= '0;
                state <= ST_RANGE;
              end
              rtdhc_pkg::OP_CLEAR: begin
                range_count <= '0;
                seen_count  <= '0;
                state       <= ST_EMIT;
              end
              default: begin
                state <= ST_EMIT;
              end
            endcase
          end
        end
        ST_RANGE: begin
          if (range_re) begin
            ridx <= ridx + 1'b1;
          end
          if (range_hit) begin
            state <= ST_SEEN;
          end else if (!range_re) begin
            state <= ST_EMIT;
          end
        end
        ST_SEEN: begin
          if (seen_re) begin
            sidx <= sidx + 1'b1;
          end
          if (seen_we) begin
            seen_count <= seen_count + 1'b1;
          end
          if (seen_match || !seen_re) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // per-word result flags
  always_ff @(posedge clk) begin
    if (accept) begin
      qid       <= in_id;
      res_hit   <= 1'b0;
      res_fresh <= 1'b0;
      res_full  <= (s_axis_tuser == rtdhc_pkg::OP_LOAD) && range_full;
    end else begin
      if (range_hit) begin
        res_hit <= 1'b1;
      end
      // new identifier: recorded if there is room, otherwise flagged full
      if ((state == ST_SEEN) && !seen_match && !seen_re) begin
        res_fresh <= !seen_full;
        res_full  <= seen_full;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      m_axis_tdata <= rtdhc_pkg::OUT_DATA_W'({res_full, cnt_out, res_fresh, res_hit});
    end
  end

endmodule
